// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms, reset-qualified on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dht_pkg.sv =====
// ----------------------------------------------------------------------------
// dht_pkg
// Types and constants shared by the DHT table builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dht_pkg;

  localparam int unsigned NUM_LENGTHS = 16;
  localparam int unsigned CIDX_W      = 4;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CODE_W      = 16;
  localparam int unsigned NEXT_W      = 17;
  localparam int unsigned RUN_W       = 18;
  localparam int unsigned TBL_W       = 3;

  localparam logic [CIDX_W-1:0] CIDX_LAST = 4'd15;

  typedef enum logic [1:0] {
    REC_BOUND  = 2'd0,
    REC_SYMBOL = 2'd1,
    REC_ERROR  = 2'd2
  } rec_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_INDEX = 2'd1,
    ERR_TRUNCATED = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_COUNTS  = 2'd1,
    PH_SYMBOLS = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_SKIP   = 4'd2,
    OP_HEADER = 4'd3,
    OP_COUNT  = 4'd4,
    OP_SYMBOL = 4'd5,
    OP_CHECK  = 4'd6,
    OP_OVER   = 4'd7,
    OP_TRUNC  = 4'd8,
    OP_BOUND  = 4'd9,
    OP_INIT   = 4'd10
  } op_t;

  typedef struct packed {
    rec_kind_t         record_kind;
    logic [TBL_W-1:0]  table_index;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_value;
    logic [CODE_W-1:0] max_code;
    logic              length_empty;
    logic [7:0]        symbol;
    err_code_t         error_code;
    logic              last_result;
  } rec_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic   skip;
    phase_t phase;
    logic   count_last;
    logic   last;
    logic   sym_done;
    logic   over;
    logic   total_nz;
    logic   loop_last;
    logic   out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dht_in_if.sv =====
// ----------------------------------------------------------------------------
// dht_in_if
// Byte channel into the DHT table builder: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dht_out_if.sv =====
// ----------------------------------------------------------------------------
// dht_out_if
// Record channel out of the DHT table builder: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [2:0]  table_index;
  logic [4:0]  code_length;
  logic [15:0] code_value;
  logic [15:0] max_code;
  logic        length_empty;
  logic [7:0]  symbol;
  logic [1:0]  error_code;
  logic        last_result;

  modport source (
    output valid, output record_kind, output table_index, output code_length,
    output code_value, output max_code, output length_empty, output symbol,
    output error_code, output last_result, input ready
  );
  modport sink (
    input valid, input record_kind, input table_index, input code_length,
    input code_value, input max_code, input length_empty, input symbol,
    input error_code, input last_result, output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/dht_dpath.sv =====
// ----------------------------------------------------------------------------
// dht_dpath
// Datapath: count store, code-space check, bound and symbol code generation,
// output record register.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_dpath #(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned NUM_TABLES   = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic           in_last_byte,
  input  wire logic           out_ready,
  input  dht_pkg::cmd_t       cmd,
  output dht_pkg::stat_t      stat,
  output logic                out_valid,
  output dht_pkg::rec_t       out_rec
);

  localparam int unsigned NL     = dht_pkg::NUM_LENGTHS;
  localparam int unsigned CIDX_W = dht_pkg::CIDX_W;
  localparam int unsigned LEN_W  = dht_pkg::LEN_W;
  localparam int unsigned NEXT_W = dht_pkg::NEXT_W;
  localparam int unsigned RUN_W  = dht_pkg::RUN_W;
  localparam int unsigned TBL_W  = dht_pkg::TBL_W;

  // latched input beat
  logic [7:0]          byte_r;
  logic                last_r;

  // count store
  logic [7:0]          counts_r [NL];
  logic [NL-1:0]       nz_r;
  logic                cnt_we;

  dht_pkg::phase_t     phase_r, phase_nxt;
  logic [CIDX_W-1:0]   cidx_r, cidx_nxt;
  logic [LEN_W-1:0]    cur_r, cur_nxt;
  logic [7:0]          left_r, left_nxt;
  logic [NEXT_W-1:0]   code_r, code_nxt;
  logic [TBL_W-1:0]    tsel_r, tsel_nxt;
  logic                skip_r, skip_nxt;
  logic [CIDX_W-1:0]   loop_r, loop_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic                anz_r, anz_nxt;
  logic                out_valid_r;
  dht_pkg::rec_t       out_rec_r;

  logic                emit;
  dht_pkg::rec_t       rec;

  // next-length search
  logic [LEN_W-1:0]    adv_base;
  logic [NL-1:0]       cand;
  logic                adv_found;
  logic [CIDX_W-1:0]   adv_j;
  logic [LEN_W-1:0]    adv_len;
  logic [LEN_W-1:0]    adv_sh;

  logic [CIDX_W-1:0]   rd_idx;
  logic [7:0]          rd_cnt;
  logic                rd_nz;

  logic [LEN_W-1:0]    chk_len;
  logic [RUN_W-1:0]    run_sum;
  logic [RUN_W-1:0]    lim;
  logic                over_now;
  logic                loop_last;
  logic                sym_done;
  logic                out_free;
  logic [NEXT_W-1:0]   nc1;
  logic [5:0]          hdr_idx;
  logic                hdr_bad;

  assign adv_base = (phase_r == dht_pkg::PH_SYMBOLS) ? cur_r : '0;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      cand[k] = nz_r[k] && (LEN_W'(k) >= adv_base);
    end
  end

  always_comb begin
    adv_j = '0;
    for (int k = NL - 1; k >= 0; k--) begin
      if (cand[k]) begin
        adv_j = CIDX_W'(k);
      end
    end
  end

  assign adv_found = |cand;
  assign adv_len   = {1'b0, adv_j} + LEN_W'(1);
  assign adv_sh    = adv_len - cur_r;

  assign rd_idx = (cmd.op == dht_pkg::OP_CHECK || cmd.op == dht_pkg::OP_BOUND) ?
                  loop_r : adv_j;
  assign rd_cnt = counts_r[rd_idx];
  assign rd_nz  = (rd_cnt != 8'd0);

  assign chk_len   = {1'b0, loop_r} + LEN_W'(1);
  assign run_sum   = run_r + RUN_W'(rd_cnt);
  assign lim       = RUN_W'(1) << chk_len;
  assign over_now  = (chk_len > LEN_W'(MAX_CODE_LEN)) ? rd_nz : (run_sum > lim);
  assign loop_last = (loop_r == dht_pkg::CIDX_LAST);
  assign sym_done  = (left_r == 8'd1) && !adv_found;
  assign out_free  = !out_valid_r || out_ready;
  assign nc1       = code_r + NEXT_W'(1);
  assign hdr_idx   = {1'b0, byte_r[7:4], 1'b0} + {2'b00, byte_r[3:0]};
  assign hdr_bad   = (hdr_idx >= 6'(NUM_TABLES));

  always_comb begin
    phase_nxt = phase_r;
    cidx_nxt  = cidx_r;
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    code_nxt  = code_r;
    tsel_nxt  = tsel_r;
    skip_nxt  = skip_r;
    loop_nxt  = loop_r;
    run_nxt   = run_r;
    anz_nxt   = anz_r;
    cnt_we    = 1'b0;
    emit      = 1'b0;
    rec       = '0;
    unique case (cmd.op)
      dht_pkg::OP_SKIP: begin
        if (last_r) begin
          skip_nxt  = 1'b0;
          phase_nxt = dht_pkg::PH_HEADER;
          cidx_nxt  = '0;
        end
      end
      dht_pkg::OP_HEADER: begin
        rec.record_kind = dht_pkg::REC_ERROR;
        rec.last_result = 1'b1;
        if (hdr_bad) begin
          emit           = 1'b1;
          rec.error_code = dht_pkg::ERR_BAD_INDEX;
          skip_nxt       = !last_r;
          phase_nxt      = dht_pkg::PH_HEADER;
        end else begin
          tsel_nxt        = hdr_idx[TBL_W-1:0];
          cidx_nxt        = '0;
          phase_nxt       = dht_pkg::PH_COUNTS;
          emit            = last_r;
          rec.error_code  = dht_pkg::ERR_TRUNCATED;
          rec.table_index = hdr_idx[TBL_W-1:0];
        end
        if (last_r) begin
          phase_nxt = dht_pkg::PH_HEADER;
          cidx_nxt  = '0;
        end
      end
      dht_pkg::OP_COUNT: begin
        cnt_we = 1'b1;
        if (cidx_r != dht_pkg::CIDX_LAST) begin
          cidx_nxt = cidx_r + CIDX_W'(1);
          if (last_r) begin
            emit            = 1'b1;
            rec.record_kind = dht_pkg::REC_ERROR;
            rec.table_index = tsel_r;
            rec.error_code  = dht_pkg::ERR_TRUNCATED;
            rec.last_result = 1'b1;
            phase_nxt       = dht_pkg::PH_HEADER;
            cidx_nxt        = '0;
          end
        end else begin
          loop_nxt = '0;
          run_nxt  = '0;
          anz_nxt  = 1'b0;
        end
      end
      dht_pkg::OP_CHECK: begin
        loop_nxt = loop_r + CIDX_W'(1);
        anz_nxt  = anz_r | rd_nz;
        run_nxt  = loop_last ? '0 : {run_sum[RUN_W-2:0], 1'b0};
      end
      dht_pkg::OP_BOUND: begin
        emit            = 1'b1;
        rec.record_kind = dht_pkg::REC_BOUND;
        rec.table_index = tsel_r;
        rec.code_length = chk_len;
        rec.last_result = loop_last;
        if (rd_nz) begin
          rec.code_value = run_r[dht_pkg::CODE_W-1:0];
          rec.max_code   = run_sum[dht_pkg::CODE_W-1:0] - dht_pkg::CODE_W'(1);
        end else begin
          rec.length_empty = 1'b1;
        end
        loop_nxt = loop_r + CIDX_W'(1);
        run_nxt  = {run_sum[RUN_W-2:0], 1'b0};
      end
      dht_pkg::OP_INIT: begin
        if (adv_found) begin
          cur_nxt   = adv_len;
          left_nxt  = rd_cnt;
          code_nxt  = '0;
          phase_nxt = dht_pkg::PH_SYMBOLS;
        end else begin
          phase_nxt = dht_pkg::PH_HEADER;
        end
        if (last_r) begin
          phase_nxt = dht_pkg::PH_HEADER;
          cidx_nxt  = '0;
        end
      end
      dht_pkg::OP_SYMBOL: begin
        emit            = 1'b1;
        rec.record_kind = dht_pkg::REC_SYMBOL;
        rec.table_index = tsel_r;
        rec.code_length = cur_r;
        rec.code_value  = code_r[dht_pkg::CODE_W-1:0];
        rec.symbol      = byte_r;
        rec.last_result = sym_done || !last_r;
        if (left_r != 8'd1) begin
          left_nxt = left_r - 8'd1;
          code_nxt = nc1;
        end else if (adv_found) begin
          cur_nxt  = adv_len;
          left_nxt = rd_cnt;
          code_nxt = nc1 << adv_sh;
        end else begin
          phase_nxt = dht_pkg::PH_HEADER;
        end
        if (last_r) begin
          phase_nxt = dht_pkg::PH_HEADER;
          cidx_nxt  = '0;
        end
      end
      dht_pkg::OP_OVER: begin
        emit            = 1'b1;
        rec.record_kind = dht_pkg::REC_ERROR;
        rec.table_index = tsel_r;
        rec.error_code  = dht_pkg::ERR_OVERFLOW;
        rec.last_result = 1'b1;
        skip_nxt        = !last_r;
        phase_nxt       = dht_pkg::PH_HEADER;
        if (last_r) begin
          cidx_nxt = '0;
        end
      end
      dht_pkg::OP_TRUNC: begin
        emit            = 1'b1;
        rec.record_kind = dht_pkg::REC_ERROR;
        rec.table_index = tsel_r;
        rec.error_code  = dht_pkg::ERR_TRUNCATED;
        rec.last_result = 1'b1;
        phase_nxt       = dht_pkg::PH_HEADER;
        cidx_nxt        = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dht_pkg::PH_HEADER;
      cidx_r      <= '0;
      cur_r       <= LEN_W'(1);
      left_r      <= '0;
      code_r      <= '0;
      tsel_r      <= '0;
      skip_r      <= 1'b0;
      loop_r      <= '0;
      run_r       <= '0;
      anz_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cidx_r      <= cidx_nxt;
      cur_r       <= cur_nxt;
      left_r      <= left_nxt;
      code_r      <= code_nxt;
      tsel_r      <= tsel_nxt;
      skip_r      <= skip_nxt;
      loop_r      <= loop_nxt;
      run_r       <= run_nxt;
      anz_r       <= anz_nxt;
      out_valid_r <= emit || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == dht_pkg::OP_LOAD) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
    if (cnt_we) begin
      counts_r[cidx_r] <= byte_r;
      nz_r[cidx_r]     <= (byte_r != 8'd0);
    end
    if (emit) begin
      out_rec_r <= rec;
    end
  end

  assign stat.skip       = skip_r;
  assign stat.phase      = phase_r;
  assign stat.count_last = (cidx_r == dht_pkg::CIDX_LAST);
  assign stat.last       = last_r;
  assign stat.sym_done   = sym_done;
  assign stat.over       = over_now;
  assign stat.total_nz   = anz_r | rd_nz;
  assign stat.loop_last  = loop_last;
  assign stat.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dht_ctrl.sv =====
// ----------------------------------------------------------------------------
// dht_ctrl
// Controller: sequences beat intake, decode, code-space check, bound and error
// record emission, and locating the first used length.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_ctrl (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  dht_pkg::stat_t stat,
  output dht_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_OVER   = 7'b0001000,
    S_TRUNC  = 7'b0010000,
    S_BOUND  = 7'b0100000,
    S_INIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = dht_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = dht_pkg::OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.skip) begin
          cmd.op    = dht_pkg::OP_SKIP;
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          unique case (stat.phase)
            dht_pkg::PH_COUNTS: begin
              cmd.op    = dht_pkg::OP_COUNT;
              state_nxt = stat.count_last ? S_CHECK : S_IDLE;
            end
            dht_pkg::PH_SYMBOLS: begin
              cmd.op    = dht_pkg::OP_SYMBOL;
              state_nxt = (stat.last && !stat.sym_done) ? S_TRUNC : S_IDLE;
            end
            default: begin
              cmd.op    = dht_pkg::OP_HEADER;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CHECK: begin
        cmd.op = dht_pkg::OP_CHECK;
        if (stat.over) begin
          state_nxt = S_OVER;
        end else if (stat.loop_last) begin
          state_nxt = (stat.last && stat.total_nz) ? S_TRUNC : S_BOUND;
        end
      end
      S_OVER: begin
        if (stat.out_free) begin
          cmd.op    = dht_pkg::OP_OVER;
          state_nxt = S_IDLE;
        end
      end
      S_TRUNC: begin
        if (stat.out_free) begin
          cmd.op    = dht_pkg::OP_TRUNC;
          state_nxt = S_IDLE;
        end
      end
      S_BOUND: begin
        if (stat.out_free) begin
          cmd.op = dht_pkg::OP_BOUND;
          if (stat.loop_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.op    = dht_pkg::OP_INIT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dht_canonical_huffman_builder.sv =====
// ----------------------------------------------------------------------------
// dht_canonical_huffman_builder
// Builds canonical Huffman codes from DHT segment payload bytes.
// in_bus carries one payload byte per beat, last_byte on the final one.
// out_bus carries result records: 16 length-bound records after a table's
// sixteenth count byte, one code record per symbol byte, and error records.
// A beat is taken in the idle state and decoded in the decode state, which
// waits while the output register is full. The sixteenth count byte starts a
// code-space check over the stored counts that stops at an overflow; unless
// the segment then ends with symbols owed, one bound record per cycle follows
// while the output register is free, then the first used length is located.
// A symbol byte that ends a segment early also brings a truncation record.
// A single output register decouples the sides; while out_bus stalls, the
// block still accepts the next beat and holds in decode until the register
// frees. Synchronous reset returns the block to awaiting a table header.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dht_canonical_huffman_builder #(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned NUM_TABLES   = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dht_in_if.sink     in_bus,
  dht_out_if.source  out_bus
);

  dht_pkg::cmd_t  cmd;
  dht_pkg::stat_t stat;
  logic           in_ready;
  logic           out_valid;
  dht_pkg::rec_t  out_rec;

  dht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dht_dpath #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_TABLES   (NUM_TABLES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_bus.data_byte),
    .in_last_byte (in_bus.last_byte),
    .out_ready    (out_bus.ready),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_rec      (out_rec)
  );

  assign in_bus.ready         = in_ready;
  assign out_bus.valid        = out_valid;
  assign out_bus.record_kind  = out_rec.record_kind;
  assign out_bus.table_index  = out_rec.table_index;
  assign out_bus.code_length  = out_rec.code_length;
  assign out_bus.code_value   = out_rec.code_value;
  assign out_bus.max_code     = out_rec.max_code;
  assign out_bus.length_empty = out_rec.length_empty;
  assign out_bus.symbol       = out_rec.symbol;
  assign out_bus.error_code   = out_rec.error_code;
  assign out_bus.last_result  = out_rec.last_result;

  // one beat in flight: intake closes right after an accept
  `DHT_ASSERT_NXT(a_one_beat, in_bus.valid && in_ready, !in_ready, "second beat accepted")

  `DHT_ASSERT_IMP(a_err_fields, out_valid && out_rec.record_kind == dht_pkg::REC_ERROR && out_rec.code_length == '0 && out_rec.code_value == '0 || !(out_valid && out_rec.record_kind == dht_pkg::REC_ERROR), 1'b1 && (!(out_valid && out_rec.record_kind == dht_pkg::REC_ERROR) || out_rec.code_length == '0), "error record carries a length")

  `DHT_ASSERT_IMP(a_bound_order, out_valid && out_rec.record_kind == dht_pkg::REC_BOUND && !out_rec.length_empty, out_rec.max_code >= out_rec.code_value, "bound max below min")

  // symbol records always carry a nonzero code length
  `DHT_ASSERT_IMP(a_symbol_nonempty, out_valid && out_rec.record_kind == dht_pkg::REC_SYMBOL, out_rec.code_length != '0, "symbol record with zero length")

endmodule

`default_nettype wire

// ===== test/dht_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_record_checker
// Watches the byte and record channels of the DHT table builder. For every
// accepted byte it works out the records the block owes, keeps them in order
// and compares each accepted record against the oldest one, field by field.
// ----------------------------------------------------------------------------
module dht_record_checker
  import dht_pkg::*;
#(
  parameter int unsigned MAX_LEN  = 16,
  parameter int unsigned N_TABLES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  dht_in_if          in_bus,
  dht_out_if         out_bus,
  output int         fail_count,
  output int         pending,
  output int         beats,
  output int         bound_recs,
  output int         code_recs,
  output int         error_recs,
  output logic [3:0] err_seen
);

  phase_t      ph;
  logic        skip;
  logic [3:0]  cnt_idx;
  logic [7:0]  len_counts [16];
  logic [4:0]  cur_len;
  logic [7:0]  left_len;
  logic [16:0] run_code;
  logic [2:0]  tsel;
  rec_t        due_records [$];
  int          reports;

  function automatic rec_t make_rec(rec_kind_t kind, logic [2:0] tbl, logic [4:0] len,
                                    logic [15:0] code, logic [15:0] maxc, logic empty,
                                    logic [7:0] sym, err_code_t err);
    rec_t r;
    r.record_kind  = kind;
    r.table_index  = tbl;
    r.code_length  = len;
    r.code_value   = code;
    r.max_code     = maxc;
    r.length_empty = empty;
    r.symbol       = sym;
    r.error_code   = err;
    r.last_result  = 1'b0;
    return r;
  endfunction

  function automatic rec_t error_rec(logic [2:0] tbl, err_code_t err);
    return make_rec(REC_ERROR, tbl, '0, '0, '0, 1'b0, '0, err);
  endfunction

  function automatic string show(rec_t r);
    return $sformatf("kind=%0d tbl=%0d len=%0d code=%h max=%h empty=%b sym=%h err=%0d last=%b",
                     r.record_kind, r.table_index, r.code_length, r.code_value, r.max_code,
                     r.length_empty, r.symbol, r.error_code, r.last_result);
  endfunction

  // step to the next length that still has codes; 1 when the table is done
  function automatic logic next_used_length();
    while (left_len == 8'd0) begin
      if (cur_len >= 5'd16) return 1'b1;
      run_code = run_code << 1;
      cur_len  = cur_len + 5'd1;
      left_len = len_counts[4'(cur_len - 5'd1)];
    end
    return 1'b0;
  endfunction

  task automatic build_records(input logic [7:0] b, input logic lst);
    rec_t        batch [$];
    int unsigned code;
    int unsigned total;
    int unsigned c;
    int unsigned idx;
    int unsigned len;
    logic        over;
    if (skip) begin
      if (lst) begin
        skip    = 1'b0;
        ph      = PH_HEADER;
        cnt_idx = '0;
      end
    end else begin
      case (ph)
        PH_COUNTS: begin
          len_counts[cnt_idx] = b;
          if (cnt_idx != CIDX_LAST) begin
            cnt_idx = cnt_idx + 4'd1;
            if (lst) batch.push_back(error_rec(tsel, ERR_TRUNCATED));
          end else begin
            code  = 0;
            total = 0;
            over  = 1'b0;
            for (len = 1; len <= 16; len++) begin
              c = len_counts[len - 1];
              total += c;
              if (len > MAX_LEN) over = (c != 0);
              else if (code + c > (32'd1 << len)) over = 1'b1;
              if (over) break;
              code = (code + c) << 1;
            end
            if (over) begin
              batch.push_back(error_rec(tsel, ERR_OVERFLOW));
              if (!lst) skip = 1'b1;
              ph = PH_HEADER;
            end else if (lst && total != 0) begin
              batch.push_back(error_rec(tsel, ERR_TRUNCATED));
            end else begin
              code = 0;
              for (len = 1; len <= 16; len++) begin
                c = len_counts[len - 1];
                if (c == 0)
                  batch.push_back(make_rec(REC_BOUND, tsel, 5'(len), '0, '0, 1'b1, '0,
                                           ERR_NONE));
                else
                  batch.push_back(make_rec(REC_BOUND, tsel, 5'(len), 16'(code),
                                           16'(code + c - 1), 1'b0, '0, ERR_NONE));
                code = (code + c) << 1;
              end
              cur_len  = 5'd1;
              run_code = '0;
              left_len = len_counts[0];
              ph = next_used_length() ? PH_HEADER : PH_SYMBOLS;
            end
          end
        end
        PH_SYMBOLS: begin
          batch.push_back(make_rec(REC_SYMBOL, tsel, cur_len, run_code[15:0], '0, 1'b0, b,
                                   ERR_NONE));
          run_code = run_code + 17'd1;
          left_len = left_len - 8'd1;
          if (next_used_length()) ph = PH_HEADER;
          else if (lst) batch.push_back(error_rec(tsel, ERR_TRUNCATED));
        end
        default: begin
          idx = 2 * int'(b[7:4]) + int'(b[3:0]);
          if (idx >= N_TABLES) begin
            batch.push_back(error_rec(3'd0, ERR_BAD_INDEX));
            if (!lst) skip = 1'b1;
            ph = PH_HEADER;
          end else begin
            tsel    = 3'(idx);
            cnt_idx = '0;
            ph      = PH_COUNTS;
            if (lst) batch.push_back(error_rec(tsel, ERR_TRUNCATED));
          end
        end
      endcase
      if (lst) begin
        ph      = PH_HEADER;
        cnt_idx = '0;
      end
      if (batch.size() != 0) batch[batch.size() - 1].last_result = 1'b1;
      foreach (batch[i]) due_records.push_back(batch[i]);
    end
  endtask

  always @(posedge clk) begin : watch
    rec_t seen;
    rec_t want;
    logic bad;
    if (!rst_n) begin
      ph       = PH_HEADER;
      skip     = 1'b0;
      cnt_idx  = '0;
      cur_len  = 5'd1;
      left_len = '0;
      run_code = '0;
      tsel     = '0;
      foreach (len_counts[i]) len_counts[i] = '0;
      due_records.delete();
      fail_count = 0;
      pending    = 0;
      beats      = 0;
      bound_recs = 0;
      code_recs  = 0;
      error_recs = 0;
      err_seen   = '0;
      reports    = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen.record_kind  = rec_kind_t'(out_bus.record_kind);
        seen.table_index  = out_bus.table_index;
        seen.code_length  = out_bus.code_length;
        seen.code_value   = out_bus.code_value;
        seen.max_code     = out_bus.max_code;
        seen.length_empty = out_bus.length_empty;
        seen.symbol       = out_bus.symbol;
        seen.error_code   = err_code_t'(out_bus.error_code);
        seen.last_result  = out_bus.last_result;
        case (seen.record_kind)
          REC_BOUND:  bound_recs++;
          REC_SYMBOL: code_recs++;
          default: begin
            error_recs++;
            err_seen[seen.error_code] = 1'b1;
          end
        endcase
        if (due_records.size() == 0) begin
          fail_count++;
          if (reports < 10) $display("unexpected record: %s", show(seen));
          reports++;
        end else begin
          want = due_records.pop_front();
          bad = (seen.record_kind  !== want.record_kind)  ||
                (seen.table_index  !== want.table_index)  ||
                (seen.code_length  !== want.code_length)  ||
                (seen.code_value   !== want.code_value)   ||
                (seen.max_code     !== want.max_code)     ||
                (seen.length_empty !== want.length_empty) ||
                (seen.symbol       !== want.symbol)       ||
                (seen.error_code   !== want.error_code)   ||
                (seen.last_result  !== want.last_result);
          if (bad) begin
            fail_count++;
            if (reports < 10) begin
              $display("record mismatch at %0t", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
            reports++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        beats++;
        build_records(in_bus.data_byte, in_bus.last_byte);
      end
      pending = due_records.size();
    end
  end

endmodule

// ===== test/dht_canonical_huffman_builder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_canonical_huffman_builder_tb
// Feeds DHT segment payloads into the table builder: a few short directed
// segments, then random segments built mostly from well-formed tables with
// random counts and symbols, mixed with truncated, overflowing, bad-index
// and noise segments. Sender bursts and receiver stalls are random, with long
// receiver hold-offs before the fourth and twelfth random segments. A side
// checker predicts and compares the records.
module dht_canonical_huffman_builder_tb;
  import dht_pkg::*;

  localparam int unsigned MAX_LEN     = 16;
  localparam int unsigned N_TABLES    = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned ITEM_GOAL   = 350;
  localparam int unsigned DRAIN_WAIT  = 80;

  typedef enum int {
    TBL_GOOD, TBL_PARTIAL, TBL_OVERFLOW, TBL_BAD_INDEX, TBL_CUT_HEADER,
    TBL_CUT_COUNTS, TBL_CUT_LAST_COUNT, TBL_EMPTY, TBL_NOISE
  } tbl_shape_t;

  typedef enum int {CNT_SPARSE, CNT_DENSE, CNT_OVER} count_shape_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       hold_req;
  int         fail_count;
  int         pending;
  int         beats;
  int         bound_recs;
  int         code_recs;
  int         error_recs;
  logic [3:0] err_seen;
  logic [7:0] seg [$];
  logic [7:0] tcounts [16];
  int         tcount_total;
  int         useful;
  int         burst_left;
  int         idle_max;

  dht_in_if  in_bus ();
  dht_out_if out_bus ();

  dht_canonical_huffman_builder #(
    .MAX_CODE_LEN(MAX_LEN),
    .NUM_TABLES  (N_TABLES)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  dht_record_checker #(
    .MAX_LEN (MAX_LEN),
    .N_TABLES(N_TABLES)
  ) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .fail_count(fail_count),
    .pending   (pending),
    .beats     (beats),
    .bound_recs(bound_recs),
    .code_recs (code_recs),
    .error_recs(error_recs),
    .err_seen  (err_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : rx_drive
    rx_mode_t mode;
    int       left;
    out_bus.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          RX_OPEN:   out_bus.ready <= 1'b1;
          RX_HALF:   out_bus.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_bus.ready <= ($urandom_range(0, 3) != 0);
          default:   out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, idle_max);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= lst;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic play_segment();
    foreach (seg[i]) send_beat(seg[i], i == seg.size() - 1);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic counted);
    seg.push_back(b);
    if (counted) useful++;
  endtask

  function automatic logic [7:0] good_header();
    int hi;
    int lo;
    hi = $urandom_range(0, 3);
    lo = $urandom_range(0, N_TABLES - 1 - 2 * hi);
    return {4'(hi), 4'(lo)};
  endfunction

  function automatic logic [7:0] bad_header();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (2 * int'(b[7:4]) + int'(b[3:0]) < N_TABLES);
    return b;
  endfunction

  // sparse: few short codes, dense: fills the code space, over: overflows
  // at one short length and leaves random counts behind it
  task automatic gen_counts(input count_shape_t shape);
    int code;
    int avail;
    int cap;
    int c;
    int ovl;
    int len;
    code = 0;
    tcount_total = 0;
    ovl = $urandom_range(1, 7);
    for (len = 1; len <= 16; len++) begin
      avail = (1 << len) - code;
      cap = (avail < 255) ? avail : 255;
      if (shape == CNT_OVER && len > ovl) begin
        c = $urandom_range(0, 255);
      end else if (shape == CNT_OVER && len == ovl) begin
        c = $urandom_range(avail + 1, 255);
      end else if (shape == CNT_DENSE) begin
        if ($urandom_range(0, 1) == 1) c = $urandom_range(cap > 2 ? cap - 2 : 0, cap);
        else c = $urandom_range(0, cap);
      end else begin
        if (cap > 4) cap = 4;
        if (cap > 12 - tcount_total) cap = 12 - tcount_total;
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap) : 0;
      end
      tcounts[len - 1] = 8'(c);
      tcount_total += c;
      code = (code + c) << 1;
    end
  endtask

  function automatic tbl_shape_t pick_shape();
    int w;
    w = $urandom_range(0, 99);
    if (w < 40) return TBL_GOOD;
    if (w < 52) return TBL_PARTIAL;
    if (w < 62) return TBL_OVERFLOW;
    if (w < 70) return TBL_BAD_INDEX;
    if (w < 74) return TBL_CUT_HEADER;
    if (w < 80) return TBL_CUT_COUNTS;
    if (w < 86) return TBL_CUT_LAST_COUNT;
    if (w < 92) return TBL_EMPTY;
    return TBL_NOISE;
  endfunction

  task automatic add_table(input tbl_shape_t shape, output logic stop);
    int n;
    stop = 1'b1;
    case (shape)
      TBL_GOOD, TBL_EMPTY: begin
        add_byte(good_header(), 1'b1);
        if (shape == TBL_EMPTY) begin
          foreach (tcounts[i]) tcounts[i] = '0;
          tcount_total = 0;
        end else begin
          gen_counts(CNT_SPARSE);
        end
        foreach (tcounts[i]) add_byte(tcounts[i], 1'b1);
        repeat (tcount_total) add_byte(8'($urandom_range(0, 255)), 1'b1);
        stop = 1'b0;
      end
      TBL_PARTIAL: begin
        add_byte(good_header(), 1'b1);
        gen_counts($urandom_range(0, 1) ? CNT_DENSE : CNT_SPARSE);
        foreach (tcounts[i]) add_byte(tcounts[i], 1'b1);
        if (tcount_total < 2) n = tcount_total;
        else n = $urandom_range(1, tcount_total - 1 < 10 ? tcount_total - 1 : 10);
        repeat (n) add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      TBL_OVERFLOW: begin
        add_byte(good_header(), 1'b1);
        gen_counts(CNT_OVER);
        foreach (tcounts[i]) add_byte(tcounts[i], 1'b1);
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      TBL_BAD_INDEX: begin
        add_byte(bad_header(), 1'b1);
        repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      TBL_CUT_HEADER: begin
        add_byte(good_header(), 1'b1);
      end
      TBL_CUT_COUNTS: begin
        add_byte(good_header(), 1'b1);
        repeat ($urandom_range(1, 15)) add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      TBL_CUT_LAST_COUNT: begin
        add_byte(good_header(), 1'b1);
        gen_counts(CNT_SPARSE);
        if (tcount_total == 0) tcounts[15] = 8'd1;
        foreach (tcounts[i]) add_byte(tcounts[i], 1'b1);
      end
      default: begin
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  initial begin : stimulus
    int   seg_no;
    int   ntab;
    logic stop;
    rst_n            = 1'b0;
    hold_req         = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    burst_left       = 0;
    idle_max         = 4;
    useful           = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // bad index alone, bad index with skipped tail, cut on header,
    // cut on a count byte, then an all-empty table
    seg = '{8'hFF};
    play_segment();
    seg = '{8'h1F, 8'hAB, 8'h00};
    play_segment();
    seg = '{8'h13};
    play_segment();
    seg = '{8'h00, 8'h01, 8'h02};
    play_segment();
    seg = '{8'h07};
    repeat (16) seg.push_back(8'h00);
    play_segment();

    useful = 0;
    seg_no = 0;
    while (useful < ITEM_GOAL) begin
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      if (seg_no == 3 || seg_no == 11) hold_req = 1'b1;
      seg.delete();
      ntab = $urandom_range(1, 3);
      for (int t = 0; t < ntab; t++) begin
        add_table(pick_shape(), stop);
        if (stop) break;
      end
      play_segment();
      seg_no++;
    end
    in_bus.valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d byte beats; checked %0d bound, %0d code and %0d error records.",
             beats, bound_recs, code_recs, error_recs);
    $display("Error codes seen (overflow, truncated, bad index): %b", err_seen[3:1]);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dht_pkg.sv
hw/rtl/dht_in_if.sv
hw/rtl/dht_out_if.sv
hw/rtl/dht_dpath.sv
hw/rtl/dht_ctrl.sv
hw/rtl/dht_canonical_huffman_builder.sv
test/dht_record_checker.sv
test/dht_canonical_huffman_builder_tb.sv
